[rtl/core/gbn_pkg.sv]
// Shared types and constants for the go-back-N sender window.
`default_nettype none
package gbn_pkg;

  // Largest window the sender keeps in flight beyond the base.
  localparam int unsigned MAX_WINDOW = 32;

  // Configuration address width: four word registers.
  localparam int unsigned CFG_AW = 4;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_PACKET  = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_CANCEL  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ACT_SEND   = 3'd0,
    ACT_FIN    = 3'd1,
    ACT_WAIT   = 3'd2,
    ACT_DONE   = 3'd3,
    ACT_FAIL   = 3'd4,
    ACT_CANCEL = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    REG_WINDOW  = 2'd0,
    REG_RETRIES = 2'd1,
    REG_COUNT   = 2'd2,
    REG_XFER_ID = 2'd3
  } reg_idx_t;

  // Where the decode step sends the sequencer next.
  typedef enum logic [1:0] {
    RT_ADVANCE,
    RT_FIN,
    RT_STATUS
  } route_t;

  typedef struct packed {
    logic latch;
    logic decode;
    logic advance;
    logic send;
    logic fin;
    logic status;
  } cmd_t;

  typedef struct packed {
    logic   slot_free;
    logic   base_done;
    logic   more;
    route_t route;
  } sts_t;

endpackage
`default_nettype wire

[rtl/core/gbn_if.sv]
// Request channel interfaces for events in and commands out.
`default_nettype none
interface gbn_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] ack_number;
  logic [31:0] rx_transfer_id;
  logic        is_ack;
  logic        from_peer;

  modport source (output valid, opcode, ack_number, rx_transfer_id, is_ack, from_peer,
                  input ready);
  modport sink (input valid, opcode, ack_number, rx_transfer_id, is_ack, from_peer,
                output ready);
endinterface

interface gbn_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] sequence_res;
  logic        last;

  modport source (output valid, action, sequence_res, last, input ready);
  modport sink (input valid, action, sequence_res, last, output ready);
endinterface
`default_nettype wire

[rtl/core/gbn_ctrl.sv]
// Sequencer that steps the datapath through one event at a time.
`default_nettype none
module gbn_ctrl
  import gbn_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ADVANCE,
    S_SEND,
    S_FIN,
    S_STATUS
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        unique case (sts.route)
          RT_ADVANCE: state_nxt = S_ADVANCE;
          RT_FIN:     state_nxt = S_FIN;
          default:    state_nxt = S_STATUS;
        endcase
      end
      S_ADVANCE: begin
        cmd.advance = 1'b1;
        state_nxt   = sts.base_done ? S_FIN : S_SEND;
      end
      S_SEND: begin
        if (!sts.more) begin
          state_nxt = S_STATUS;
        end else if (sts.slot_free) begin
          cmd.send = 1'b1;
        end
      end
      S_FIN: begin
        if (sts.slot_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_STATUS;
        end
      end
      S_STATUS: begin
        if (sts.slot_free) begin
          cmd.status = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  // A result is only loaded into a free output slot.
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.send || cmd.fin || cmd.status) |-> sts.slot_free)
    else $error("result loaded into a busy output slot");

  // At most one result is produced per cycle.
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.send, cmd.fin, cmd.status}))
    else $error("more than one result in a cycle");

  // An accepted event is decoded in the following cycle.
  a_decode_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> cmd.decode)
    else $error("accepted event not decoded");

endmodule
`default_nettype wire

[rtl/core/gbn_dp.sv]
// Datapath: configuration registers, window state, event decode and result register.
`default_nettype none
module gbn_dp
  import gbn_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  // Configuration port
  input  wire                cfg_psel,
  input  wire                cfg_penable,
  input  wire                cfg_pwrite,
  input  wire  [CFG_AW-1:0]  cfg_paddr,
  input  wire  [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  // Event fields
  input  wire  [1:0]         in_opcode,
  input  wire  [31:0]        in_ack_number,
  input  wire  [31:0]        in_rx_transfer_id,
  input  wire                in_is_ack,
  input  wire                in_from_peer,
  // Result channel
  output logic               out_valid,
  input  wire                out_ready,
  output logic [2:0]         out_action,
  output logic [31:0]        out_sequence_res,
  output logic               out_last,
  // Sequencer link
  input  cmd_t               cmd,
  output sts_t               sts
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DATA,
    PH_FINISH,
    PH_DONE,
    PH_FAILED,
    PH_CANCELLED
  } phase_t;

  localparam logic [5:0] MaxWin = 6'(MAX_WINDOW);

  // Configuration
  logic [5:0]  win_cfg_r;
  logic [7:0]  retry_lim_r;
  logic [31:0] pkt_total_r;
  logic [31:0] xfer_id_r;

  // Latched event
  op_t         op_r;
  logic [31:0] ack_r;
  logic        good_r;

  // Window state
  phase_t      phase_r, phase_nxt;
  logic [31:0] base_r, base_nxt;
  logic [31:0] next_r, next_nxt;
  logic [7:0]  retry_r, retry_nxt;
  logic [32:0] wend_r;

  // Result register
  logic        out_valid_r;
  act_t        out_action_r;
  logic [31:0] out_seq_r;
  logic        out_last_r;

  logic        cfg_wr;
  reg_idx_t    cfg_idx;
  logic [5:0]  eff_win;
  logic [7:0]  eff_ret;
  logic [7:0]  retry_inc;
  logic        ack_ok;
  logic        fin_ok;
  route_t      route;
  act_t        status_act;

  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_WINDOW:  cfg_prdata = {26'd0, win_cfg_r};
      REG_RETRIES: cfg_prdata = {24'd0, retry_lim_r};
      REG_COUNT:   cfg_prdata = pkt_total_r;
      REG_XFER_ID: cfg_prdata = xfer_id_r;
      default:     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cfg_r   <= 6'd1;
      retry_lim_r <= 8'd5;
      pkt_total_r <= '0;
      xfer_id_r   <= 32'd1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WINDOW:  win_cfg_r   <= cfg_pwdata[5:0];
        REG_RETRIES: retry_lim_r <= cfg_pwdata[7:0];
        REG_COUNT:   pkt_total_r <= cfg_pwdata;
        REG_XFER_ID: xfer_id_r   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // Zero window acts as one; oversize windows are clamped.
  always_comb begin
    eff_win = (win_cfg_r == 6'd0) ? 6'd1 : win_cfg_r;
    if (eff_win > MaxWin) eff_win = MaxWin;
  end

  assign eff_ret   = (retry_lim_r == 8'd0) ? 8'd1 : retry_lim_r;
  assign retry_inc = retry_r + 8'd1;

  assign ack_ok = good_r && (ack_r >= base_r) && (ack_r < next_r) && (ack_r < pkt_total_r);
  assign fin_ok = (op_r == OP_PACKET) && good_r && (ack_r == pkt_total_r);

  always_comb begin
    case (phase_r)
      PH_DONE:      status_act = ACT_DONE;
      PH_FAILED:    status_act = ACT_FAIL;
      PH_CANCELLED: status_act = ACT_CANCEL;
      default:      status_act = ACT_WAIT;
    endcase
  end

  // Event decode and window updates.
  always_comb begin
    phase_nxt = phase_r;
    base_nxt  = base_r;
    next_nxt  = next_r;
    retry_nxt = retry_r;
    route     = RT_STATUS;

    if (op_r == OP_START) begin
      base_nxt  = '0;
      next_nxt  = '0;
      retry_nxt = '0;
      phase_nxt = PH_DATA;
      route     = RT_ADVANCE;
    end else if (op_r == OP_CANCEL) begin
      if (phase_r == PH_IDLE || phase_r == PH_DATA || phase_r == PH_FINISH) begin
        phase_nxt = PH_CANCELLED;
      end
    end else if (phase_r == PH_DATA) begin
      if (op_r == OP_TIMEOUT) begin
        retry_nxt = retry_inc;
        if (retry_inc >= eff_ret) begin
          phase_nxt = PH_FAILED;
        end else begin
          next_nxt = base_r;
          route    = RT_ADVANCE;
        end
      end else begin
        if (ack_ok) begin
          base_nxt  = ack_r + 32'd1;
          retry_nxt = '0;
        end
        route = RT_ADVANCE;
      end
    end else if (phase_r == PH_FINISH) begin
      if (fin_ok) begin
        phase_nxt = PH_DONE;
      end else begin
        retry_nxt = retry_inc;
        if (retry_inc >= eff_ret) begin
          phase_nxt = PH_FAILED;
        end else begin
          route = RT_FIN;
        end
      end
    end

    if (!cmd.decode) begin
      phase_nxt = phase_r;
      base_nxt  = base_r;
      next_nxt  = next_r;
      retry_nxt = retry_r;
    end

    if (cmd.advance && sts.base_done) begin
      phase_nxt = PH_FINISH;
      retry_nxt = '0;
    end

    if (cmd.send) begin
      next_nxt = next_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      base_r  <= '0;
      next_r  <= '0;
      retry_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      base_r  <= base_nxt;
      next_r  <= next_nxt;
      retry_r <= retry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= op_t'(in_opcode);
      ack_r  <= in_ack_number;
      good_r <= in_from_peer && in_is_ack && (in_rx_transfer_id == xfer_id_r);
    end
    if (cmd.advance) begin
      wend_r <= {1'b0, base_r} + {27'd0, eff_win};
    end
  end

  // Result register; reloads in the cycle the held result is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.send || cmd.fin || cmd.status) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.send) begin
      out_action_r <= ACT_SEND;
      out_seq_r    <= next_r;
      out_last_r   <= 1'b0;
    end else if (cmd.fin) begin
      out_action_r <= ACT_FIN;
      out_seq_r    <= pkt_total_r;
      out_last_r   <= 1'b0;
    end else if (cmd.status) begin
      out_action_r <= status_act;
      out_seq_r    <= '0;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_action       = out_action_r;
  assign out_sequence_res = out_seq_r;
  assign out_last         = out_last_r;

  assign sts.slot_free = !out_valid_r || out_ready;
  assign sts.base_done = (base_r >= pkt_total_r);
  assign sts.more      = (next_r < pkt_total_r) && ({1'b0, next_r} < wend_r);
  assign sts.route     = route;

  // The base never passes the next sequence to send.
  a_base_le_next: assert property (@(posedge clk) disable iff (!rst_n)
    base_r <= next_r)
    else $error("window base beyond next sequence");

  // Only send and finish commands are non-final results.
  a_nonlast_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_action_r == ACT_SEND || out_action_r == ACT_FIN))
    else $error("status result without last flag");

  // A send command always carries a sequence below the packet count.
  a_send_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.send |-> (next_r < pkt_total_r))
    else $error("send beyond packet count");

endmodule
`default_nettype wire

[rtl/core/go_back_n_sender_window.sv]
// Top level of the go-back-N sender window: sequencer plus datapath.
//
//   Channel   Direction  Carries
//   in_ch     sink       event request: opcode, ack_number, rx_transfer_id, is_ack, from_peer
//   out_ch    source     command request: action, sequence_res, last
//   cfg_*     slave      APB access to the window, retry limit, packet total and id registers
//
// One event is handled at a time. An event with a single result steps through accept,
// decode and status. A window refill steps through accept, decode, advance, the sends,
// a step that finds the window full, and status. A finish attempt steps through accept,
// decode, finish and status after a packet or a timeout in the finish phase, with the
// advance step before finish when it is entered through the advance step.
// The sequencer steps through these, one result per cycle into the output register
// while the output slot is free. Reset is synchronous and active low; it restores the
// register defaults and an idle window. No clearing pass is needed after reset.
// A stalled result holds the sequencer in place; the block takes the next event as
// soon as the final status result of the current one is loaded, even while it waits.
`default_nettype none
module go_back_n_sender_window
  import gbn_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  gbn_in_if.sink            in_ch,
  gbn_out_if.source         out_ch,
  input  wire               cfg_psel,
  input  wire               cfg_penable,
  input  wire               cfg_pwrite,
  input  wire  [CFG_AW-1:0] cfg_paddr,
  input  wire  [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  cmd_t cmd;
  sts_t sts;

  // Writes complete in their access cycle.
  assign cfg_pready = 1'b1;

  // The sequencer decides when each request moves and which step runs.
  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the registers, the window state and the result register.
  gbn_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .in_opcode         (in_ch.opcode),
    .in_ack_number     (in_ch.ack_number),
    .in_rx_transfer_id (in_ch.rx_transfer_id),
    .in_is_ack         (in_ch.is_ack),
    .in_from_peer      (in_ch.from_peer),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_action        (out_ch.action),
    .out_sequence_res  (out_ch.sequence_res),
    .out_last          (out_ch.last),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule
`default_nettype wire
